// ===== hw/rtl/qmn_pkg.sv =====
// ----------------------------------------------------------------------------
// qmn_pkg - shared constants and types for the quaternion product core
// Widths of the fixed-point datapath, the Hamilton term tables and the
// small-magnitude threshold used by the normalizer.
// ----------------------------------------------------------------------------
package qmn_pkg;

  localparam int COMPONENT_BITS = 32;
  localparam int FRACTION_BITS  = 28;

  // Exact product, sum and magnitude widths
  localparam int PROD_BITS = 2 * COMPONENT_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int MAG_BITS  = PROD_BITS + 1;
  localparam int HI_BITS   = MAG_BITS - COMPONENT_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int M2_BITS   = 2 * MAG_BITS + 2;
  localparam int ROOT_BITS = M2_BITS / 2;
  localparam int QUO_BITS  = FRACTION_BITS + 1;
  localparam int RES_BITS  = (QUO_BITS > COMPONENT_BITS ? QUO_BITS : COMPONENT_BITS) + 1;

  // Threshold in output units, at least one
  localparam longint TINY_RAW       = ((64'sd1 <<< FRACTION_BITS) + 500000) / 1000000;
  localparam longint TINY_THRESHOLD = (TINY_RAW == 0) ? 1 : TINY_RAW;
  localparam logic [M2_BITS-1:0] TINY_LIMIT =
    M2_BITS'(TINY_THRESHOLD * TINY_THRESHOLD) << (2 * FRACTION_BITS);
  localparam logic signed [COMPONENT_BITS-1:0] TINY_BOUND = COMPONENT_BITS'(TINY_THRESHOLD);

  // Largest normalized component: 1.0, or the most positive code if 1.0 does not fit
  localparam longint UNIT_RAW = (FRACTION_BITS < COMPONENT_BITS - 1) ?
    (64'sd1 <<< FRACTION_BITS) : ((64'sd1 <<< (COMPONENT_BITS - 1)) - 1);
  localparam logic signed [COMPONENT_BITS-1:0] UNIT_BOUND = COMPONENT_BITS'(UNIT_RAW);

  // Saturation limits on the output magnitude
  localparam logic [RES_BITS-1:0] POS_LIMIT =
    RES_BITS'((64'sd1 <<< (COMPONENT_BITS - 1)) - 1);
  localparam logic [RES_BITS-1:0] NEG_LIMIT = RES_BITS'(64'sd1 <<< (COMPONENT_BITS - 1));
  localparam logic [MAG_BITS:0]   HALF_UNIT = (MAG_BITS + 1)'(64'sd1 <<< (FRACTION_BITS - 1));

  // Hamilton product: right operand index and subtract mask per output component
  localparam logic [1:0] TERM_RIGHT [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };
  localparam logic [3:0] TERM_MINUS [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  // Sign and magnitude of the four product components
  typedef struct packed {
    logic [3:0]               neg;
    logic [3:0][MAG_BITS-1:0] mag;
  } qd_t;

endpackage

// ===== hw/rtl/qmn_if.sv =====
// ----------------------------------------------------------------------------
// qmn_if - request and result channels of the quaternion product core
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface qmn_req_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    left_w;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    left_x;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    left_y;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    left_z;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    right_w;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    right_x;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    right_y;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    right_z;

  modport source (output valid, left_w, left_x, left_y, left_z,
                  right_w, right_x, right_y, right_z, input ready);
  modport sink   (input valid, left_w, left_x, left_y, left_z,
                  right_w, right_x, right_y, right_z, output ready);
endinterface

interface qmn_res_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    prod_w;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    prod_x;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    prod_y;
  logic signed [qmn_pkg::COMPONENT_BITS-1:0]    prod_z;
  logic                                         tiny_magnitude;

  modport source (output valid, prod_w, prod_x, prod_y, prod_z, tiny_magnitude,
                  input ready);
  modport sink   (input valid, prod_w, prod_x, prod_y, prod_z, tiny_magnitude,
                  output ready);
endinterface

// ===== hw/rtl/quaternion_multiply_normalize_core.sv =====
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_core - normalized Hamilton quaternion product
// Exact fixed-point product of two quaternions, scaled to unit length.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the skid register is empty, and each
// gives one result. The depth is set by the square root, which settles one
// root bit per stage (66 stages), and by the four parallel dividers, which
// settle one quotient bit per stage (29 stages); seven stages of multiply and
// sum come before and two of rounding and saturation after. A two-entry
// output (final stage plus skid register) lets the pipeline take a request
// in the cycle in which the result side stalls. When the product
// magnitude is below about 1e-6 the rounded raw product is given and
// tiny_magnitude is set.
module quaternion_multiply_normalize_core (
  input  logic      clk,
  input  logic      rst,
  qmn_req_if.sink   req,
  qmn_res_if.source rsp
);
  import qmn_pkg::*;

  logic en;
  logic skid_valid;

  // Advance the whole pipeline unless the skid register is occupied
  assign en        = !skid_valid;
  assign req.ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: sixteen partial products
  logic signed [COMPONENT_BITS-1:0] lq [4];
  logic signed [COMPONENT_BITS-1:0] rq [4];
  logic                             v1;
  logic signed [PROD_BITS-1:0]      p1 [4][4];

  assign lq[0] = req.left_w;
  assign lq[1] = req.left_x;
  assign lq[2] = req.left_y;
  assign lq[3] = req.left_z;
  assign rq[0] = req.right_w;
  assign rq[1] = req.right_x;
  assign rq[2] = req.right_y;
  assign rq[3] = req.right_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          p1[c][k] <= lq[k] * rq[TERM_RIGHT[c][k]];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: signed sums of the Hamilton terms
  logic                        v2;
  logic signed [SUM_BITS-1:0]  sum2 [4];
  logic signed [SUM_BITS-1:0]  p2   [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum2[c] = '0;
      for (int k = 0; k < 4; k++) begin
        if (TERM_MINUS[c][k]) begin
          sum2[c] = sum2[c] - SUM_BITS'(p1[c][k]);
        end else begin
          sum2[c] = sum2[c] + SUM_BITS'(p1[c][k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2 <= sum2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: split into sign and magnitude
  logic                v3;
  qd_t                 q3;
  qd_t                 q3_next;
  logic [SUM_BITS-1:0] abs3 [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      q3_next.neg[c] = p2[c][SUM_BITS-1];
      abs3[c]        = q3_next.neg[c] ? SUM_BITS'(-p2[c]) : SUM_BITS'(p2[c]);
      q3_next.mag[c] = abs3[c][MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q3 <= q3_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: partial products of each square
  logic                              v4;
  qd_t                               q4;
  logic [2*HI_BITS-1:0]              hh4 [4];
  logic [HI_BITS+COMPONENT_BITS-1:0] hl4 [4];
  logic [2*COMPONENT_BITS-1:0]       ll4 [4];

  always_ff @(posedge clk) begin
    if (en) begin
      q4 <= q3;
      for (int c = 0; c < 4; c++) begin
        hh4[c] <= q3.mag[c][MAG_BITS-1:COMPONENT_BITS] * q3.mag[c][MAG_BITS-1:COMPONENT_BITS];
        hl4[c] <= q3.mag[c][MAG_BITS-1:COMPONENT_BITS] * q3.mag[c][COMPONENT_BITS-1:0];
        ll4[c] <= q3.mag[c][COMPONENT_BITS-1:0] * q3.mag[c][COMPONENT_BITS-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: assemble each square
  logic               v5;
  qd_t                q5;
  logic [SQ_BITS-1:0] sq5 [4];

  always_ff @(posedge clk) begin
    if (en) begin
      q5 <= q4;
      for (int c = 0; c < 4; c++) begin
        sq5[c] <= (SQ_BITS'(hh4[c]) << (2 * COMPONENT_BITS))
                + (SQ_BITS'(hl4[c]) << (COMPONENT_BITS + 1))
                + SQ_BITS'(ll4[c]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6 and 7: sum of squares
  logic             v6;
  qd_t              q6;
  logic [SQ_BITS:0] s6 [2];
  logic               v7;
  qd_t                q7;
  logic [M2_BITS-1:0] m2_7;

  always_ff @(posedge clk) begin
    if (en) begin
      q6    <= q5;
      s6[0] <= {1'b0, sq5[0]} + {1'b0, sq5[1]};
      s6[1] <= {1'b0, sq5[2]} + {1'b0, sq5[3]};
      q7    <= q6;
      m2_7  <= M2_BITS'(s6[0]) + M2_BITS'(s6[1]);
    end
  end

  // --------------------------------------------------------------------------
  // Square root: one root bit per stage
  logic                 sv    [ROOT_BITS];
  logic [M2_BITS-1:0]   sm2   [ROOT_BITS];
  logic [ROOT_BITS+1:0] srem  [ROOT_BITS];
  logic [ROOT_BITS-1:0] sroot [ROOT_BITS];
  qd_t                  sqd   [ROOT_BITS];
  logic                 stiny [ROOT_BITS];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_sqrt
    logic                 v_in;
    logic [M2_BITS-1:0]   m2_in;
    logic [ROOT_BITS+1:0] rem_in;
    logic [ROOT_BITS-1:0] root_in;
    qd_t                  qd_in;
    logic                 tiny_in;
    logic [ROOT_BITS+3:0] rem_sh;
    logic [ROOT_BITS+3:0] trial;
    logic                 take;

    if (i == 0) begin : g_first
      assign v_in    = v7;
      assign m2_in   = m2_7;
      assign rem_in  = '0;
      assign root_in = '0;
      assign qd_in   = q7;
      assign tiny_in = m2_7 < TINY_LIMIT;
    end else begin : g_next
      assign v_in    = sv[i-1];
      assign m2_in   = sm2[i-1];
      assign rem_in  = srem[i-1];
      assign root_in = sroot[i-1];
      assign qd_in   = sqd[i-1];
      assign tiny_in = stiny[i-1];
    end

    // Bring down two bits and try the next root bit
    assign rem_sh = {rem_in, m2_in[M2_BITS-1 -: 2]};
    assign trial  = (ROOT_BITS + 4)'({root_in, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[i] <= 1'b0;
      end else if (en) begin
        sv[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sm2[i]   <= m2_in << 2;
        srem[i]  <= take ? (ROOT_BITS + 2)'(rem_sh - trial) : rem_sh[ROOT_BITS+1:0];
        sroot[i] <= {root_in[ROOT_BITS-2:0], take};
        sqd[i]   <= qd_in;
        stiny[i] <= tiny_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Division of each magnitude by the root: one quotient bit per stage
  logic                           dv    [QUO_BITS];
  logic [3:0][ROOT_BITS-1:0]      drem  [QUO_BITS];
  logic [3:0][QUO_BITS-1:0]       dquo  [QUO_BITS];
  logic [ROOT_BITS-1:0]           ds    [QUO_BITS];
  qd_t                            dqd   [QUO_BITS];
  logic                           dtiny [QUO_BITS];

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    logic                      v_in;
    logic [3:0][ROOT_BITS-1:0] rem_in;
    logic [3:0][QUO_BITS-1:0]  quo_in;
    logic [ROOT_BITS-1:0]      s_in;
    qd_t                       qd_in;
    logic                      tiny_in;
    logic [3:0]                nbit;
    logic [3:0][ROOT_BITS:0]   rem_sh;
    logic [3:0]                take;
    logic [3:0][ROOT_BITS-1:0] rem_next;
    logic [3:0][QUO_BITS-1:0]  quo_next;

    // The numerator is the magnitude shifted up by the fraction width:
    // its top part seeds the remainder and only its lowest bit is brought down
    if (j == 0) begin : g_first
      assign v_in    = sv[ROOT_BITS-1];
      assign s_in    = sroot[ROOT_BITS-1];
      assign qd_in   = sqd[ROOT_BITS-1];
      assign tiny_in = stiny[ROOT_BITS-1];
      assign quo_in  = '0;
      for (genvar c = 0; c < 4; c++) begin : g_seed
        assign rem_in[c] = ROOT_BITS'(sqd[ROOT_BITS-1].mag[c] >> 1);
        assign nbit[c]   = sqd[ROOT_BITS-1].mag[c][0];
      end
    end else begin : g_next
      assign v_in    = dv[j-1];
      assign s_in    = ds[j-1];
      assign qd_in   = dqd[j-1];
      assign tiny_in = dtiny[j-1];
      assign quo_in  = dquo[j-1];
      assign rem_in  = drem[j-1];
      assign nbit    = '0;
    end

    always_comb begin
      for (int c = 0; c < 4; c++) begin
        rem_sh[c]   = {rem_in[c], nbit[c]};
        take[c]     = rem_sh[c] >= {1'b0, s_in};
        rem_next[c] = take[c] ? ROOT_BITS'(rem_sh[c] - {1'b0, s_in})
                              : rem_sh[c][ROOT_BITS-1:0];
        quo_next[c] = {quo_in[c][QUO_BITS-2:0], take[c]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[j]  <= rem_next;
        dquo[j]  <= quo_next;
        ds[j]    <= s_in;
        dqd[j]   <= qd_in;
        dtiny[j] <= tiny_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Round: half away from zero on the quotient, or on the raw product if tiny
  logic                     rv;
  logic [3:0]               rneg;
  logic [3:0][RES_BITS-1:0] rmag;
  logic                     rtiny;
  logic [3:0][RES_BITS-1:0] rmag_next;
  logic [3:0]               round_up;
  logic [3:0][MAG_BITS:0]   raw_sum;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      round_up[c]  = {drem[QUO_BITS-1][c], 1'b0} >= {1'b0, ds[QUO_BITS-1]};
      raw_sum[c]   = {1'b0, dqd[QUO_BITS-1].mag[c]} + HALF_UNIT;
      rmag_next[c] = dtiny[QUO_BITS-1] ? RES_BITS'(raw_sum[c] >> FRACTION_BITS)
                   : RES_BITS'(dquo[QUO_BITS-1][c]) + RES_BITS'(round_up[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rneg  <= dqd[QUO_BITS-1].neg;
      rmag  <= rmag_next;
      rtiny <= dtiny[QUO_BITS-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: saturate and restore the sign
  logic                                   ov;
  logic signed [COMPONENT_BITS-1:0]       ocomp [4];
  logic                                   otiny;
  logic [3:0][RES_BITS-1:0]               sat_mag;
  logic [3:0][RES_BITS-1:0]               signed_res;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (rneg[c]) begin
        sat_mag[c]    = (rmag[c] > NEG_LIMIT) ? NEG_LIMIT : rmag[c];
        signed_res[c] = RES_BITS'(0) - sat_mag[c];
      end else begin
        sat_mag[c]    = (rmag[c] > POS_LIMIT) ? POS_LIMIT : rmag[c];
        signed_res[c] = sat_mag[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        ocomp[c] <= signed_res[c][COMPONENT_BITS-1:0];
      end
      otiny <= rtiny;
    end
  end

  // Valid bits of the front and back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      rv <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      rv <= dv[QUO_BITS-1];
      ov <= rv;
    end
  end

  // --------------------------------------------------------------------------
  // Skid register: catch the final result when the result side stalls
  logic signed [COMPONENT_BITS-1:0] skid_comp [4];
  logic                             skid_tiny;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (ov && !rsp.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_comp <= ocomp;
      skid_tiny <= otiny;
    end
  end

  assign rsp.valid          = skid_valid || ov;
  assign rsp.prod_w         = skid_valid ? skid_comp[0] : ocomp[0];
  assign rsp.prod_x         = skid_valid ? skid_comp[1] : ocomp[1];
  assign rsp.prod_y         = skid_valid ? skid_comp[2] : ocomp[2];
  assign rsp.prod_z         = skid_valid ? skid_comp[3] : ocomp[3];
  assign rsp.tiny_magnitude = skid_valid ? skid_tiny : otiny;

  // --------------------------------------------------------------------------
  // Assertions
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(ov && !rsp.ready))
    else $error("skid register filled without a stalled result");

  a_tiny_bound: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.tiny_magnitude) |->
      (rsp.prod_w <= TINY_BOUND && rsp.prod_w >= -TINY_BOUND &&
       rsp.prod_x <= TINY_BOUND && rsp.prod_x >= -TINY_BOUND &&
       rsp.prod_y <= TINY_BOUND && rsp.prod_y >= -TINY_BOUND &&
       rsp.prod_z <= TINY_BOUND && rsp.prod_z >= -TINY_BOUND))
    else $error("tiny result exceeds the threshold");

  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.tiny_magnitude) |->
      (rsp.prod_w <= UNIT_BOUND && rsp.prod_w >= -UNIT_BOUND - 1 &&
       rsp.prod_x <= UNIT_BOUND && rsp.prod_x >= -UNIT_BOUND - 1 &&
       rsp.prod_y <= UNIT_BOUND && rsp.prod_y >= -UNIT_BOUND - 1 &&
       rsp.prod_z <= UNIT_BOUND && rsp.prod_z >= -UNIT_BOUND - 1))
    else $error("normalized component exceeds unit length");

endmodule
